FILE: design/gda_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date adder.
// Used by gda_cal_unit and gregorian_date_adder; depends on nothing else.
package gda_pkg;

   localparam int AMOUNT_BITS   = 12;
   localparam int YEAR_LIMIT    = 9999;
   localparam int YEAR_BITS     = 14;
   localparam int MONTH_BITS    = 4;
   localparam int DAY_BITS      = 5;
   localparam int OP_BITS       = 3;
   localparam int YEAR_IW       = 16;
   localparam int RES_BITS      = 9;
   localparam int CNT_BITS      = AMOUNT_BITS + 3;
   localparam int SUM_BITS      = AMOUNT_BITS + 8;

   localparam logic [YEAR_IW-1:0]    RES_PERIOD = YEAR_IW'(400);
   localparam logic [RES_BITS-1:0]   RES_LAST   = RES_BITS'(399);
   localparam logic [MONTH_BITS-1:0] MONTH_JAN  = MONTH_BITS'(1);
   localparam logic [MONTH_BITS-1:0] MONTH_FEB  = MONTH_BITS'(2);
   localparam logic [MONTH_BITS-1:0] MONTH_DEC  = MONTH_BITS'(12);
   localparam logic [DAY_BITS-1:0]   DAY_FIRST  = DAY_BITS'(1);

   typedef enum logic [OP_BITS-1:0] {
      OP_DAYS      = 3'd0,
      OP_WEEKS     = 3'd1,
      OP_MONTHS    = 3'd2,
      OP_YEARS     = 3'd3,
      OP_DECADES   = 3'd4,
      OP_CENTURIES = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      CAL_CLAMP = 2'd0,
      CAL_DAY   = 2'd1,
      CAL_MONTH = 2'd2
   } cal_op_type;

   typedef struct packed {
      logic [OP_BITS-1:0]     op;
      logic [AMOUNT_BITS-1:0] amount;
      logic [YEAR_BITS-1:0]   in_year;
      logic [MONTH_BITS-1:0]  in_month;
      logic [DAY_BITS-1:0]    in_day;
   } req_word_type;

   typedef struct packed {
      logic [YEAR_BITS-1:0]  out_year;
      logic [MONTH_BITS-1:0] out_month;
      logic [DAY_BITS-1:0]   out_day;
      logic                  overflow;
   } rsp_word_type;

   typedef struct packed {
      logic [YEAR_IW-1:0]    year;
      logic [MONTH_BITS-1:0] month;
      logic [DAY_BITS-1:0]   day;
      logic [RES_BITS-1:0]   r400;
   } cal_type;

   typedef struct packed {
      cal_type nxt;
      logic    limit_hit;
   } cal_step_type;

   function automatic logic is_leap(input logic [RES_BITS-1:0] r400);
      logic quad;
      logic cent;
      quad = (r400[1:0] == 2'd0);
      cent = (r400 == RES_BITS'(100)) || (r400 == RES_BITS'(200)) ||
             (r400 == RES_BITS'(300));
      return (quad && !cent) || (r400 == '0);
   endfunction

   function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] month,
                                                     input logic leap);
      logic [DAY_BITS-1:0] len;
      len = DAY_BITS'(31);
      if (month == MONTH_FEB) begin
         len = leap ? DAY_BITS'(29) : DAY_BITS'(28);
      end else if ((month == MONTH_BITS'(4)) || (month == MONTH_BITS'(6)) ||
                   (month == MONTH_BITS'(9)) || (month == MONTH_BITS'(11))) begin
         len = DAY_BITS'(30);
      end
      return len;
   endfunction

endpackage

FILE: design/gda_cal_unit.sv
// Shared calendar step unit: clamp, one-day advance or one-month advance.
// Depends on gda_pkg for the date record, op codes and month lengths.
module gda_cal_unit #(
   parameter int YEAR_LIMIT = gda_pkg::YEAR_LIMIT
) (
   input  gda_pkg::cal_op_type   cal_op,
   input  gda_pkg::cal_type      cur,
   output gda_pkg::cal_step_type step
);

   localparam logic [gda_pkg::YEAR_IW-1:0] LIMIT = gda_pkg::YEAR_IW'(YEAR_LIMIT);

   logic [gda_pkg::DAY_BITS-1:0] len_cur;
   logic [gda_pkg::DAY_BITS-1:0] len_adv;
   logic                         wrap;
   logic                         hit;
   gda_pkg::cal_type             adv;

   always_comb begin
      len_cur = gda_pkg::month_len(cur.month, gda_pkg::is_leap(cur.r400));
      wrap    = (cur.month == gda_pkg::MONTH_DEC);
      hit     = wrap && (cur.year >= LIMIT);
      adv     = cur;
      if (wrap) begin
         adv.year  = cur.year + gda_pkg::YEAR_IW'(1);
         adv.month = gda_pkg::MONTH_JAN;
         adv.r400  = (cur.r400 == gda_pkg::RES_LAST) ? '0 :
                     cur.r400 + gda_pkg::RES_BITS'(1);
      end else begin
         adv.month = cur.month + gda_pkg::MONTH_BITS'(1);
      end
      len_adv = gda_pkg::month_len(adv.month, gda_pkg::is_leap(adv.r400));

      step.nxt       = cur;
      step.limit_hit = 1'b0;
      unique case (cal_op)
         gda_pkg::CAL_CLAMP: begin
            if (cur.day > len_cur) begin
               step.nxt.day = len_cur;
            end
         end
         gda_pkg::CAL_DAY: begin
            if (cur.day >= len_cur) begin
               if (hit) begin
                  step.limit_hit = 1'b1;
               end else begin
                  step.nxt     = adv;
                  step.nxt.day = gda_pkg::DAY_FIRST;
               end
            end else begin
               step.nxt.day = cur.day + gda_pkg::DAY_BITS'(1);
            end
         end
         gda_pkg::CAL_MONTH: begin
            if (hit) begin
               step.limit_hit = 1'b1;
            end else begin
               step.nxt = adv;
               if (cur.day > len_adv) begin
                  step.nxt.day = len_adv;
               end
            end
         end
         default: begin
            step.nxt = cur;
         end
      endcase
   end

endmodule

FILE: design/gregorian_date_adder.sv
// Top level of the Gregorian date adder: sequencer, year residue reduction,
// output register. Depends on gda_pkg and gda_cal_unit.
//
//   channel   ports                                 direction
//   req       req_valid, req_stall, req_word        in  (date, op, amount)
//   rsp       rsp_valid, rsp_stall, rsp_word        out (date, overflow)
//
// One word at a time. After accept the sequencer reduces the year to its residue
// modulo 400, clamps the day, then steps one day per cycle (amount or 7*amount
// days) or one month at a time until the count runs out or the limit stops the
// walk; year ops add amount, 10*amount or 100*amount, saturate at the limit, and
// reduce and clamp again. Synchronous reset clears the sequencer and rsp_valid.
// A stalled result waits in the output register while the next word is taken;
// that word holds in the last state until the register frees.
module gregorian_date_adder #(
   parameter int YEAR_LIMIT = gda_pkg::YEAR_LIMIT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gda_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gda_pkg::rsp_word_type rsp_word
);

   localparam logic [gda_pkg::YEAR_IW-1:0]  LIMIT     = gda_pkg::YEAR_IW'(YEAR_LIMIT);
   localparam logic [gda_pkg::SUM_BITS-1:0] LIMIT_SUM = gda_pkg::SUM_BITS'(YEAR_LIMIT);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_REDUCE = 7'b0000010,
      S_CLAMP  = 7'b0000100,
      S_DAY    = 7'b0001000,
      S_MONTH  = 7'b0010000,
      S_YEAR   = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type                         state_ff, state_in;
   gda_pkg::cal_type                  cal_ff, cal_in;
   logic [gda_pkg::OP_BITS-1:0]       op_ff, op_in;
   logic [gda_pkg::AMOUNT_BITS-1:0]   amt_ff, amt_in;
   logic [gda_pkg::CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [gda_pkg::YEAR_IW-1:0]       rem_ff, rem_in;
   logic                              ovf_ff, ovf_in;
   logic                              phase_ff, phase_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   gda_pkg::rsp_word_type             rsp_word_ff, rsp_word_in;

   gda_pkg::cal_op_type               cal_op;
   gda_pkg::cal_step_type             step;
   logic [gda_pkg::YEAR_IW-1:0]       y_norm;
   logic                              y_sat;
   logic [gda_pkg::SUM_BITS-1:0]      mult_k;
   logic [gda_pkg::SUM_BITS-1:0]      new_year;
   logic                              out_free;

   gda_cal_unit #(
      .YEAR_LIMIT(YEAR_LIMIT)
   ) u_cal (
      .cal_op(cal_op),
      .cur   (cal_ff),
      .step  (step)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      y_norm = gda_pkg::YEAR_IW'(req_word.in_year);
      y_sat  = 1'b0;
      if (y_norm == '0) begin
         y_norm = gda_pkg::YEAR_IW'(1);
      end
      if (y_norm > LIMIT) begin
         y_norm = LIMIT;
         y_sat  = 1'b1;
      end
      unique case (op_ff)
         gda_pkg::OP_DECADES:   mult_k = gda_pkg::SUM_BITS'(10);
         gda_pkg::OP_CENTURIES: mult_k = gda_pkg::SUM_BITS'(100);
         default:               mult_k = gda_pkg::SUM_BITS'(1);
      endcase
      new_year = gda_pkg::SUM_BITS'(amt_ff) * mult_k + gda_pkg::SUM_BITS'(cal_ff.year);
   end

   always_comb begin
      state_in     = state_ff;
      cal_in       = cal_ff;
      op_in        = op_ff;
      amt_in       = amt_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      ovf_in       = ovf_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      cal_op       = gda_pkg::CAL_CLAMP;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_word.op;
               amt_in   = req_word.amount;
               ovf_in   = y_sat;
               phase_in = 1'b0;
               cal_in.year  = y_norm;
               cal_in.month = req_word.in_month;
               if (req_word.in_month == '0) begin
                  cal_in.month = gda_pkg::MONTH_JAN;
               end else if (req_word.in_month > gda_pkg::MONTH_DEC) begin
                  cal_in.month = gda_pkg::MONTH_DEC;
               end
               cal_in.day = (req_word.in_day == '0) ? gda_pkg::DAY_FIRST : req_word.in_day;
               cal_in.r400 = '0;
               rem_in      = y_norm;
               if (req_word.op == gda_pkg::OP_WEEKS) begin
                  cnt_in = gda_pkg::CNT_BITS'(req_word.amount) * gda_pkg::CNT_BITS'(7);
               end else begin
                  cnt_in = gda_pkg::CNT_BITS'(req_word.amount);
               end
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (rem_ff >= gda_pkg::RES_PERIOD) begin
               rem_in = rem_ff - gda_pkg::RES_PERIOD;
            end else begin
               cal_in.r400 = rem_ff[gda_pkg::RES_BITS-1:0];
               state_in    = S_CLAMP;
            end
         end
         S_CLAMP: begin
            cal_op = gda_pkg::CAL_CLAMP;
            cal_in = step.nxt;
            if (phase_ff) begin
               state_in = S_DONE;
            end else begin
               unique case (op_ff)
                  gda_pkg::OP_DAYS,
                  gda_pkg::OP_WEEKS:     state_in = S_DAY;
                  gda_pkg::OP_MONTHS:    state_in = S_MONTH;
                  gda_pkg::OP_YEARS,
                  gda_pkg::OP_DECADES,
                  gda_pkg::OP_CENTURIES: state_in = S_YEAR;
                  default:               state_in = S_DONE;
               endcase
            end
         end
         S_DAY, S_MONTH: begin
            cal_op = (state_ff == S_DAY) ? gda_pkg::CAL_DAY : gda_pkg::CAL_MONTH;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end else if (step.limit_hit) begin
               ovf_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               cal_in = step.nxt;
               cnt_in = cnt_ff - gda_pkg::CNT_BITS'(1);
            end
         end
         S_YEAR: begin
            if (new_year > LIMIT_SUM) begin
               cal_in.year = LIMIT;
               ovf_in      = 1'b1;
            end else begin
               cal_in.year = new_year[gda_pkg::YEAR_IW-1:0];
            end
            rem_in   = cal_in.year;
            phase_in = 1'b1;
            state_in = S_REDUCE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_word_in.out_year  = cal_ff.year[gda_pkg::YEAR_BITS-1:0];
               rsp_word_in.out_month = cal_ff.month;
               rsp_word_in.out_day   = cal_ff.day;
               rsp_word_in.overflow  = ovf_ff;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cal_ff      <= cal_in;
      op_ff       <= op_in;
      amt_ff      <= amt_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      ovf_ff      <= ovf_in;
      phase_ff    <= phase_in;
      rsp_word_ff <= rsp_word_in;
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted word did not start the sequencer");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (cal_ff.month >= gda_pkg::MONTH_JAN &&
                                cal_ff.month <= gda_pkg::MONTH_DEC))
      else $error("working month out of range");

   a_year_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (cal_ff.year <= LIMIT))
      else $error("working year past limit");

   a_ovf_at_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && ovf_ff) |-> (cal_ff.year == LIMIT))
      else $error("overflow raised below the year limit");

endmodule
